### rtl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg: shared types and constants of the planar point transform unit
// Mode and register codes, datapath widths, the sideband record that rides
// through the divider, and the output saturation helper.
// ----------------------------------------------------------------------------
package ppt_pkg;

  // transform modes
  localparam logic [2:0] MODE_LINE  = 3'd0;
  localparam logic [2:0] MODE_POINT = 3'd1;
  localparam logic [2:0] MODE_INV   = 3'd2;
  localparam logic [2:0] MODE_TRANS = 3'd3;
  localparam logic [2:0] MODE_ROT   = 3'd4;
  localparam logic [2:0] MODE_DIL   = 3'd5;
  localparam logic [2:0] MODE_IDENT = 3'd6;

  // configuration register indexes
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_PRESENT = 3'd1;
  localparam logic [CFG_AW-1:0] REG_AX      = 3'd2;
  localparam logic [CFG_AW-1:0] REG_AY      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_BX      = 3'd4;
  localparam logic [CFG_AW-1:0] REG_BY      = 3'd5;
  localparam logic [CFG_AW-1:0] REG_FACTOR  = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SINE    = 3'd7;

  localparam int FRAC_BITS_DEF = 16;

  // datapath widths
  localparam int BASE_W = 36;                    // offset term: 2A-P, P+B-A, A, P
  localparam int NUM_W  = 102;                   // rounded dividend 2|n|+d
  localparam int DEN_W  = 67;                    // divisor d (|B-A|^2, |P-A|^2, 1.0)
  localparam int QUO_W  = 36;                    // quotient bits, clamped above
  localparam int REM_W  = DEN_W + 1 + QUO_W;     // partial remainder
  localparam int SUM_W  = BASE_W + 2;            // offset plus signed quotient

  // sideband carried alongside the divider
  typedef struct packed {
    logic signed [BASE_W-1:0] base_x;
    logic signed [BASE_W-1:0] base_y;
    logic                     neg_x;
    logic                     neg_y;
    logic                     use_q;
    logic                     ok;
  } side_t;

  // clamp to 32-bit two's complement
  function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [31:0] r;
    if (v > $signed(SUM_W'(32'h7FFF_FFFF))) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -$signed(SUM_W'(33'h0_8000_0000))) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/ppt_div.sv
// ----------------------------------------------------------------------------
// ppt_div: pipelined restoring divider, two lanes with a shared divisor
// One quotient bit per stage after an entry stage that flags quotients too
// large for QUO_W bits; such quotients come out as all ones.
// ----------------------------------------------------------------------------
module ppt_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ppt_pkg::NUM_W-1:0]   in_num_x,
  input  logic [ppt_pkg::NUM_W-1:0]   in_num_y,
  input  logic [ppt_pkg::DEN_W:0]     in_den,
  input  ppt_pkg::side_t              in_side,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ppt_pkg::QUO_W-1:0]   out_q_x,
  output logic [ppt_pkg::QUO_W-1:0]   out_q_y,
  output ppt_pkg::side_t              out_side
);

  localparam int NS = ppt_pkg::QUO_W + 1;
  localparam int RW = ppt_pkg::REM_W;
  localparam int QW = ppt_pkg::QUO_W;

  logic                        v     [NS];
  logic                        rdy   [NS];
  logic [RW-1:0]               rem_x [NS];
  logic [RW-1:0]               rem_y [NS];
  logic [ppt_pkg::DEN_W:0]     den   [NS];
  logic [QW-1:0]               q_x   [NS];
  logic [QW-1:0]               q_y   [NS];
  logic                        sat_x [NS];
  logic                        sat_y [NS];
  ppt_pkg::side_t              side  [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    // a stage takes a beat when empty or when its successor moves
    if (g == NS - 1) begin : g_last
      assign rdy[g] = ~v[g] | out_ready;
    end else begin : g_mid
      assign rdy[g] = ~v[g] | rdy[g+1];
    end

    if (g == 0) begin : g_entry
      logic [RW-1:0] den_top;
      assign den_top = RW'(in_den) << QW;

      // load dividend, flag overflow of the quotient range
      always_ff @(posedge clk) begin
        if (rst) begin
          v[g] <= 1'b0;
        end else if (rdy[g]) begin
          v[g] <= in_valid;
        end
        if (rdy[g]) begin
          rem_x[g] <= RW'(in_num_x);
          rem_y[g] <= RW'(in_num_y);
          sat_x[g] <= RW'(in_num_x) >= den_top;
          sat_y[g] <= RW'(in_num_y) >= den_top;
          den[g]   <= in_den;
          q_x[g]   <= '0;
          q_y[g]   <= '0;
          side[g]  <= in_side;
        end
      end
    end else begin : g_bit
      localparam int SH = NS - 1 - g;
      logic [RW-1:0] sub;
      logic          ge_x;
      logic          ge_y;
      assign sub  = RW'(den[g-1]) << SH;
      assign ge_x = rem_x[g-1] >= sub;
      assign ge_y = rem_y[g-1] >= sub;

      // trial subtract, shift in one quotient bit
      always_ff @(posedge clk) begin
        if (rst) begin
          v[g] <= 1'b0;
        end else if (rdy[g]) begin
          v[g] <= v[g-1];
        end
        if (rdy[g]) begin
          rem_x[g] <= ge_x ? rem_x[g-1] - sub : rem_x[g-1];
          rem_y[g] <= ge_y ? rem_y[g-1] - sub : rem_y[g-1];
          q_x[g]   <= {q_x[g-1][QW-2:0], ge_x};
          q_y[g]   <= {q_y[g-1][QW-2:0], ge_y};
          sat_x[g] <= sat_x[g-1];
          sat_y[g] <= sat_y[g-1];
          den[g]   <= den[g-1];
          side[g]  <= side[g-1];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];
  assign out_q_x   = sat_x[NS-1] ? '1 : q_x[NS-1];
  assign out_q_y   = sat_y[NS-1] ? '1 : q_y[NS-1];
  assign out_side  = side[NS-1];

endmodule

### rtl/planar_point_transform_unit.sv
// Pipeline: 6 front stages, 37 divider stages, 1 output register.
// Throughput: one point per cycle unless the output stalls; every stage
//   moves independently, so bubbles collapse and a stalled output still
//   lets upstream stages fill.
// Reset: clears all valid bits and returns the configuration registers to
//   mode identity, reference present, A = B = 0, factor 1.0, sine 0.
// ----------------------------------------------------------------------------
// planar_point_transform_unit: Q16.16 point transform pipeline
// Reflect across a line, reflect about a point, invert in a circle,
// translate, rotate or dilate one point per beat, saturating the result.
// ----------------------------------------------------------------------------
module planar_point_transform_unit #(
  parameter int FRAC_BITS = ppt_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [ppt_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [ppt_pkg::CFG_DW-1:0]    cfg_wdata,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,   // px[31:0], py[63:32]
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [63:0]                   m_axis_tdata,   // qx[31:0], qy[63:32]
  output logic [0:0]                    m_axis_tuser    // ok[0]
);

  localparam int DW = ppt_pkg::DEN_W;
  localparam int NW = ppt_pkg::NUM_W;
  localparam int BW = ppt_pkg::BASE_W;
  localparam int SW = ppt_pkg::SUM_W;
  localparam int QW = ppt_pkg::QUO_W;
  localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [2:0]          mode;
  logic                present;
  logic signed [31:0]  ax, ay, bx, by, factor;
  logic signed [17:0]  sine;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= ppt_pkg::MODE_IDENT;
      present <= 1'b1;
      ax      <= '0;
      ay      <= '0;
      bx      <= '0;
      by      <= '0;
      factor  <= 32'sd65536;
      sine    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ppt_pkg::REG_MODE:    mode    <= cfg_wdata[2:0];
        ppt_pkg::REG_PRESENT: present <= cfg_wdata[0];
        ppt_pkg::REG_AX:      ax      <= $signed(cfg_wdata[31:0]);
        ppt_pkg::REG_AY:      ay      <= $signed(cfg_wdata[31:0]);
        ppt_pkg::REG_BX:      bx      <= $signed(cfg_wdata[31:0]);
        ppt_pkg::REG_BY:      by      <= $signed(cfg_wdata[31:0]);
        ppt_pkg::REG_FACTOR:  factor  <= $signed(cfg_wdata[31:0]);
        ppt_pkg::REG_SINE:    sine    <= $signed(cfg_wdata[17:0]);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake chain
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4, v5, v6, ov;
  logic r1, r2, r3, r4, r5, r6, ordy;
  logic div_in_ready, div_out_valid;

  assign ordy = ~ov | m_axis_tready;
  assign r6   = ~v6 | div_in_ready;
  assign r5   = ~v5 | r6;
  assign r4   = ~v4 | r5;
  assign r3   = ~v3 | r4;
  assign r2   = ~v2 | r3;
  assign r1   = ~v1 | r2;
  assign s_axis_tready = r1;

  // --------------------------------------------------------------------------
  // stage 1: differences, offset term, validity
  // --------------------------------------------------------------------------
  logic signed [31:0]   in_px, in_py;
  logic signed [32:0]   dx_c, dy_c, ex_c, ey_c;
  logic                 zero_e, zero_d, needs_ref, ok_c, useq_c;
  logic signed [BW-1:0] bx_c, by_c;

  assign in_px  = $signed(s_axis_tdata[31:0]);
  assign in_py  = $signed(s_axis_tdata[63:32]);
  assign dx_c   = 33'(in_px) - 33'(ax);
  assign dy_c   = 33'(in_py) - 33'(ay);
  assign ex_c   = 33'(bx) - 33'(ax);
  assign ey_c   = 33'(by) - 33'(ay);
  assign zero_e = (ax == bx) && (ay == by);
  assign zero_d = (in_px == ax) && (in_py == ay);
  assign needs_ref = (mode == ppt_pkg::MODE_LINE) || (mode == ppt_pkg::MODE_POINT) ||
                     (mode == ppt_pkg::MODE_INV)  || (mode == ppt_pkg::MODE_ROT)   ||
                     (mode == ppt_pkg::MODE_DIL);
  assign ok_c   = !(needs_ref && !present) && !((mode == ppt_pkg::MODE_INV) && zero_d);
  assign useq_c = ok_c && (((mode == ppt_pkg::MODE_LINE) && !zero_e) ||
                           (mode == ppt_pkg::MODE_INV) || (mode == ppt_pkg::MODE_ROT) ||
                           (mode == ppt_pkg::MODE_DIL));

  // pick the term the quotient is added to
  always_comb begin
    unique case (mode)
      ppt_pkg::MODE_LINE: begin
        bx_c = zero_e ? BW'(in_px) : (BW'(ax) <<< 1) - BW'(in_px);
        by_c = zero_e ? BW'(in_py) : (BW'(ay) <<< 1) - BW'(in_py);
      end
      ppt_pkg::MODE_POINT: begin
        bx_c = (BW'(ax) <<< 1) - BW'(in_px);
        by_c = (BW'(ay) <<< 1) - BW'(in_py);
      end
      ppt_pkg::MODE_INV, ppt_pkg::MODE_ROT, ppt_pkg::MODE_DIL: begin
        bx_c = BW'(ax);
        by_c = BW'(ay);
      end
      ppt_pkg::MODE_TRANS: begin
        bx_c = BW'(in_px) + BW'(bx) - BW'(ax);
        by_c = BW'(in_py) + BW'(by) - BW'(ay);
      end
      default: begin
        bx_c = BW'(in_px);
        by_c = BW'(in_py);
      end
    endcase
  end

  logic [2:0]          mode1;
  logic signed [32:0]  dx1, dy1, ex1, ey1;
  ppt_pkg::side_t      side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= s_axis_tvalid;
    end
    if (r1) begin
      mode1 <= mode;
      dx1   <= dx_c;
      dy1   <= dy_c;
      ex1   <= ex_c;
      ey1   <= ey_c;
      side1 <= '{base_x: bx_c, base_y: by_c, neg_x: 1'b0, neg_y: 1'b0,
                 use_q: useq_c, ok: ok_c};
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: four 33x33 products
  // --------------------------------------------------------------------------
  logic signed [32:0] f33, s33;
  logic signed [32:0] oa0, ob0, oa1, ob1, oa2, ob2, oa3, ob3;

  assign f33 = 33'(factor);
  assign s33 = 33'(sine);

  // route operands per mode
  always_comb begin
    oa0 = '0; ob0 = '0; oa1 = '0; ob1 = '0;
    oa2 = '0; ob2 = '0; oa3 = '0; ob3 = '0;
    unique case (mode1)
      ppt_pkg::MODE_LINE: begin
        oa0 = ex1; ob0 = ex1; oa1 = ey1; ob1 = ey1;
        oa2 = dx1; ob2 = ex1; oa3 = dy1; ob3 = ey1;
      end
      ppt_pkg::MODE_INV: begin
        oa0 = dx1; ob0 = dx1; oa1 = dy1; ob1 = dy1;
        oa2 = f33; ob2 = f33;
      end
      ppt_pkg::MODE_ROT: begin
        oa0 = dx1; ob0 = f33; oa1 = dy1; ob1 = s33;
        oa2 = dx1; ob2 = s33; oa3 = dy1; ob3 = f33;
      end
      ppt_pkg::MODE_DIL: begin
        oa0 = dx1; ob0 = f33; oa1 = dy1; ob1 = f33;
      end
      default: ;
    endcase
  end

  logic [2:0]          mode2;
  logic signed [65:0]  m0, m1, m2, m3;
  logic signed [32:0]  dx2, dy2, ex2, ey2;
  ppt_pkg::side_t      side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
    if (r2) begin
      mode2 <= mode1;
      m0    <= oa0 * ob0;
      m1    <= oa1 * ob1;
      m2    <= oa2 * ob2;
      m3    <= oa3 * ob3;
      dx2   <= dx1;
      dy2   <= dy1;
      ex2   <= ex1;
      ey2   <= ey1;
      side2 <= side1;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: sums - squared length, dot product, rotated numerators
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] sum01, sum23, dif01;
  logic signed [DW-1:0] a_c, nx_c, ny_c;
  logic signed [32:0]   bxo_c, byo_c;
  logic [DW-1:0]        den_c;

  assign sum01 = DW'(m0) + DW'(m1);
  assign sum23 = DW'(m2) + DW'(m3);
  assign dif01 = DW'(m0) - DW'(m1);

  always_comb begin
    a_c = '0; nx_c = '0; ny_c = '0; bxo_c = '0; byo_c = '0; den_c = ONE;
    unique case (mode2)
      ppt_pkg::MODE_LINE: begin
        a_c = sum23; bxo_c = ex2; byo_c = ey2; den_c = sum01;
      end
      ppt_pkg::MODE_INV: begin
        a_c = DW'(m2); bxo_c = dx2; byo_c = dy2; den_c = sum01;
      end
      ppt_pkg::MODE_ROT: begin
        nx_c = dif01; ny_c = sum23;
      end
      ppt_pkg::MODE_DIL: begin
        nx_c = DW'(m0); ny_c = DW'(m1);
      end
      default: ;
    endcase
  end

  logic [2:0]           mode3;
  logic signed [DW-1:0] a3, nx3, ny3;
  logic signed [32:0]   bxo3, byo3;
  logic [DW-1:0]        den3;
  ppt_pkg::side_t       side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
    if (r3) begin
      mode3 <= mode2;
      a3    <= a_c;
      nx3   <= nx_c;
      ny3   <= ny_c;
      bxo3  <= bxo_c;
      byo3  <= byo_c;
      den3  <= (den_c == '0) ? ONE : den_c;
      side3 <= side2;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: wide product split in two partial products per lane
  // --------------------------------------------------------------------------
  logic signed [34:0] a_lo;
  logic signed [32:0] a_hi;

  assign a_lo = $signed({1'b0, a3[33:0]});
  assign a_hi = $signed(a3[DW-1:34]);

  logic [2:0]           mode4;
  logic signed [67:0]   pl_x, pl_y;
  logic signed [65:0]   ph_x, ph_y;
  logic signed [DW-1:0] nx4, ny4;
  logic [DW-1:0]        den4;
  ppt_pkg::side_t       side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (r4) begin
      v4 <= v3;
    end
    if (r4) begin
      mode4 <= mode3;
      pl_x  <= a_lo * bxo3;
      pl_y  <= a_lo * byo3;
      ph_x  <= a_hi * bxo3;
      ph_y  <= a_hi * byo3;
      nx4   <= nx3;
      ny4   <= ny3;
      den4  <= den3;
      side4 <= side3;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: recombine partial products into signed numerators
  // --------------------------------------------------------------------------
  logic signed [NW-1:0] prod_x, prod_y, num_x_c, num_y_c;

  assign prod_x = (NW'(ph_x) <<< 34) + NW'(pl_x);
  assign prod_y = (NW'(ph_y) <<< 34) + NW'(pl_y);

  always_comb begin
    unique case (mode4)
      ppt_pkg::MODE_LINE: begin
        num_x_c = prod_x <<< 1;
        num_y_c = prod_y <<< 1;
      end
      ppt_pkg::MODE_INV: begin
        num_x_c = prod_x;
        num_y_c = prod_y;
      end
      default: begin
        num_x_c = NW'(nx4);
        num_y_c = NW'(ny4);
      end
    endcase
  end

  logic signed [NW-1:0] num_x5, num_y5;
  logic [DW-1:0]        den5;
  ppt_pkg::side_t       side5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (r5) begin
      v5 <= v4;
    end
    if (r5) begin
      num_x5 <= num_x_c;
      num_y5 <= num_y_c;
      den5   <= den4;
      side5  <= side4;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: round-half-away dividend 2|n|+d and divisor 2d
  // --------------------------------------------------------------------------
  localparam int EW = NW + 2;
  logic signed [EW-1:0] den_e, n2_x, n2_y, rn_x, rn_y;
  logic                 neg_x_c, neg_y_c;

  assign den_e   = $signed({{(EW-DW){1'b0}}, den5});
  assign n2_x    = EW'(num_x5) <<< 1;
  assign n2_y    = EW'(num_y5) <<< 1;
  assign neg_x_c = num_x5[NW-1];
  assign neg_y_c = num_y5[NW-1];
  assign rn_x    = neg_x_c ? den_e - n2_x : n2_x + den_e;
  assign rn_y    = neg_y_c ? den_e - n2_y : n2_y + den_e;

  logic [NW-1:0]  dvd_x6, dvd_y6;
  logic [DW:0]    dvs6;
  ppt_pkg::side_t side6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (r6) begin
      v6 <= v5;
    end
    if (r6) begin
      dvd_x6 <= rn_x[NW-1:0];
      dvd_y6 <= rn_y[NW-1:0];
      dvs6   <= {den5, 1'b0};
      side6  <= '{base_x: side5.base_x, base_y: side5.base_y, neg_x: neg_x_c,
                  neg_y: neg_y_c, use_q: side5.use_q, ok: side5.ok};
    end
  end

  // --------------------------------------------------------------------------
  // divider
  // --------------------------------------------------------------------------
  logic [QW-1:0]  dq_x, dq_y;
  ppt_pkg::side_t dside;

  ppt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v6),
    .in_ready  (div_in_ready),
    .in_num_x  (dvd_x6),
    .in_num_y  (dvd_y6),
    .in_den    (dvs6),
    .in_side   (side6),
    .out_valid (div_out_valid),
    .out_ready (ordy),
    .out_q_x   (dq_x),
    .out_q_y   (dq_y),
    .out_side  (dside)
  );

  // --------------------------------------------------------------------------
  // output register: apply sign, add offset, saturate
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] qv_x, qv_y, base_x, base_y, sum_x, sum_y;

  assign qv_x   = $signed({{(SW-QW){1'b0}}, dq_x});
  assign qv_y   = $signed({{(SW-QW){1'b0}}, dq_y});
  assign base_x = SW'(dside.base_x);
  assign base_y = SW'(dside.base_y);
  assign sum_x  = !dside.use_q ? base_x : (dside.neg_x ? base_x - qv_x : base_x + qv_x);
  assign sum_y  = !dside.use_q ? base_y : (dside.neg_y ? base_y - qv_y : base_y + qv_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ordy) begin
      ov <= div_out_valid;
    end
    if (ordy) begin
      m_axis_tdata[31:0]  <= dside.ok ? ppt_pkg::sat32(sum_x) : 32'd0;
      m_axis_tdata[63:32] <= dside.ok ? ppt_pkg::sat32(sum_y) : 32'd0;
      m_axis_tuser[0]     <= dside.ok;
    end
  end

  assign m_axis_tvalid = ov;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
    else $error("invalid result carries nonzero coordinates");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output register is empty");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    v6 |-> dvs6 != '0)
    else $error("zero divisor entered the divider");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule
